// File: rtl/ows_pkg.sv
// Shared types, codes and constants for the oscillator waveform shaper.
// Holds the quarter-wave sine entry function used to build the table ROM.
// No dependencies.
`timescale 1ns / 1ps

package ows_pkg;

  // Wave select codes
  localparam logic [2:0] KIND_SQUARE   = 3'd0;
  localparam logic [2:0] KIND_SAW      = 3'd1;
  localparam logic [2:0] KIND_TRIANGLE = 3'd2;
  localparam logic [2:0] KIND_SINE     = 3'd3;
  localparam logic [2:0] KIND_NOISE    = 3'd4;

  // Noise generator seeds
  localparam logic [31:0] NOISE_A_RST = 32'h6745_2301;
  localparam logic [31:0] NOISE_B_RST = 32'hefcd_ab89;

  // pi in Q30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

  typedef logic signed [15:0] sample_t;

  // Clamp an 18-bit intermediate to Q1.15
  function automatic sample_t sat16(input logic signed [17:0] v);
    sample_t r;
    if (v > 18'sd32767) begin
      r = SAMPLE_MAX;
    end else if (v < -18'sd32768) begin
      r = SAMPLE_MIN;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // One quarter-wave entry: round(32768*sin(pi/2*i/2^ab)), saturated.
  // Q30 Taylor series through the u^11 term. Elaboration-time only.
  function automatic logic [14:0] sine_entry(input int unsigned ab, input int unsigned i);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    u    = (64'(i) * PI_Q30) >> (ab + 1);
    u2   = (u * u) >> 30;
    term = u;
    sum  = u;
    term = ((term * u2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * u2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * u2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * u2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * u2) >> 30) / 64'd110;
    sum  = sum - term;
    v = (sum * 64'd32768 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

// File: rtl/ows_in_if.sv
// Input channel of the waveform shaper: valid/ready plus kind and phase.
// Depends on nothing; PHASE_BITS sets the phase width.
`timescale 1ns / 1ps

interface ows_in_if #(
  parameter int PHASE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            kind;
  logic [PHASE_BITS-1:0] phase;

  modport source (output valid, output kind, output phase, input ready);
  modport sink   (input valid, input kind, input phase, output ready);
endinterface

// File: rtl/ows_out_if.sv
// Result channel of the waveform shaper: valid/ready plus a Q1.15 sample.
// Depends on nothing.
`timescale 1ns / 1ps

interface ows_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/ows_sine_rom.sv
// Quarter-wave sine ROM, 2^ADDR_BITS + 1 entries, registered read.
// Depends on ows_pkg (sine_entry).
`timescale 1ns / 1ps

module ows_sine_rom #(
  parameter int ADDR_BITS = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [ADDR_BITS:0]   addr,
  output logic [14:0]          rd_data
);
  import ows_pkg::*;

  localparam int DEPTH = (2 ** ADDR_BITS) + 1;

  logic [14:0] tab [DEPTH];
  logic [14:0] rd_data_r;

  // Constant contents, built at elaboration
  for (genvar g = 0; g < DEPTH; g++) begin : g_tab
    assign tab[g] = sine_entry(ADDR_BITS, g);
  end

  // Registered read, held while the pipeline stalls
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r <= tab[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/oscillator_waveform_shaper.sv
// Oscillator waveform shaper top level: square, saw, triangle, sine, noise.
// Depends on ows_pkg, ows_in_if, ows_out_if and ows_sine_rom.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          kind[2:0], phase[PHASE_BITS-1:0]
//   out_ch   out  valid/ready          sample[15:0] signed Q1.15
//
// One transaction per cycle while out_ch is not stalled. An accepted item passes
// through stage 1 (beside the ROM's registered read), then the output register.
// Reset (rst_n low, synchronous) empties the pipeline and reloads the noise seeds.
// A stall on out_ch freezes both stages; in_ch.ready drops only while the output
// register is full and not being taken.
`timescale 1ns / 1ps

module oscillator_waveform_shaper #(
  parameter int PHASE_BITS           = 16,
  parameter int SINE_TABLE_ADDR_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  ows_in_if.sink   in_ch,
  ows_out_if.source out_ch
);
  import ows_pkg::*;

  localparam int PB    = PHASE_BITS;
  localparam int AB    = SINE_TABLE_ADDR_BITS;
  localparam int TAB_N = 2 ** AB;

  logic adv;
  logic in_fire;

  logic [PB-1:0]       phase;
  logic [2:0]          kind;
  logic [PB+15:0]      saw_w;
  logic [PB+15:0]      tri_w;
  logic [PB+AB+1:0]    sin_w;
  logic [15:0]         saw_x;
  logic [15:0]         tri_x;
  logic [AB+1:0]       sin_t;
  logic [AB:0]         rom_addr;
  logic [14:0]         rom_q;

  sample_t             shape;
  logic                is_sine;
  logic                neg;

  logic                s1_val_r;
  sample_t             s1_sample_r;
  logic                s1_sine_r;
  logic                s1_neg_r;

  logic                out_valid_r;
  sample_t             out_sample_r;
  sample_t             out_sample_nxt;

  logic [31:0]         noise_a_r, noise_a_nxt;
  logic [31:0]         noise_b_r, noise_b_nxt;

  // Handshake: pipeline advances whenever the output register can take data
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid && adv;

  assign phase = in_ch.phase;
  assign kind  = in_ch.kind;

  // Phase scaling by constant shifts
  assign saw_w = {phase, 16'b0};
  assign saw_x = saw_w[PB+15:PB];
  assign tri_w = {phase[PB-2:0], 17'b0};
  assign tri_x = tri_w[PB+15:PB];
  assign sin_w = {phase, {(AB + 2){1'b0}}};
  assign sin_t = sin_w[PB+AB+1:PB];

  // Sine table address, mirrored in odd quadrants
  always_comb begin
    if (sin_t[AB]) begin
      rom_addr = (AB + 1)'(TAB_N) - {1'b0, sin_t[AB-1:0]};
    end else begin
      rom_addr = {1'b0, sin_t[AB-1:0]};
    end
  end

  // Stage 0 shape select
  always_comb begin
    shape   = '0;
    is_sine = 1'b0;
    neg     = 1'b0;
    case (kind)
      KIND_SQUARE: begin
        shape = phase[PB-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end
      KIND_SAW: begin
        shape = sat16(18'sd32768 - $signed({2'b00, saw_x}));
      end
      KIND_TRIANGLE: begin
        if (phase[PB-1]) begin
          shape = sat16(-18'sd32768 + $signed({2'b00, tri_x}));
        end else begin
          shape = sat16(18'sd32768 - $signed({2'b00, tri_x}));
        end
      end
      KIND_SINE: begin
        is_sine = 1'b1;
        neg     = sin_t[AB+1];
      end
      KIND_NOISE: begin
        shape = noise_b_r[31:16];
      end
      default: begin
        shape = '0;
      end
    endcase
  end

  ows_sine_rom #(
    .ADDR_BITS (AB)
  ) u_rom (
    .clk     (clk),
    .en      (adv),
    .addr    (rom_addr),
    .rd_data (rom_q)
  );

  // Stage 1 register, aligned with the ROM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_val_r  <= 1'b0;
      s1_sine_r <= 1'b0;
      s1_neg_r  <= 1'b0;
    end else if (adv) begin
      s1_val_r  <= in_fire;
      s1_sine_r <= is_sine;
      s1_neg_r  <= neg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample_r <= shape;
    end
  end

  // Sine sign fix-up and result select
  always_comb begin
    if (s1_sine_r) begin
      out_sample_nxt = s1_neg_r ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
    end else begin
      out_sample_nxt = s1_sample_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;

  // Noise generator: xor then add, once per noise transaction
  always_comb begin
    noise_a_nxt = noise_a_r;
    noise_b_nxt = noise_b_r;
    if (in_fire && kind == KIND_NOISE) begin
      noise_a_nxt = noise_a_r ^ noise_b_r;
      noise_b_nxt = noise_b_r + (noise_a_r ^ noise_b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_a_r <= NOISE_A_RST;
      noise_b_r <= NOISE_B_RST;
    end else begin
      noise_a_r <= noise_a_nxt;
      noise_b_r <= noise_b_nxt;
    end
  end

  // Checks
  a_noise_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && kind == KIND_NOISE) |=> $stable(noise_a_r) && $stable(noise_b_r))
    else $error("noise state changed without a noise transaction");

  a_fill_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_val_r)
    else $error("accepted transaction missing from stage 1");

  a_neg_sine: assert property (@(posedge clk) disable iff (!rst_n)
    s1_neg_r |-> s1_sine_r)
    else $error("negate flag set on a non-sine item");

endmodule
